[rtl/map_pkg.sv]
// Shared types and constants of the mass-action propensity block.
package map_pkg;

  // Fixed field widths.
  localparam int ORDER_W   = 3;
  localparam int RATE_W    = 48;
  localparam int PROD_W    = 64;
  localparam int CFG_IDX_W = 1;

  // Highest reactant order that contributes a falling factorial.
  localparam logic [ORDER_W-1:0] MAX_ORDER = 3'd4;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RATE_CONST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE     = 1'd1;

  // Entry classes decided by the front.
  localparam logic [1:0] KIND_SKIP = 2'd0;
  localparam logic [1:0] KIND_MUL  = 2'd1;
  localparam logic [1:0] KIND_ZERO = 2'd2;
  localparam logic [1:0] KIND_BAD  = 2'd3;

  // Control part of one queued species entry.
  typedef struct packed {
    logic [1:0]         kind;
    logic [ORDER_W-1:0] order;
    logic               last;
  } entry_ctl_t;

  // Status of the shared multiplier.
  typedef struct packed {
    logic done;
    logic sat;
  } mul_stat_t;

endpackage

[rtl/map_front.sv]
// Front end: classifies species entries and queues them for the back end.
module map_front #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_order,
  input  logic [31:0]           in_count,
  input  logic                  in_last_species,
  output logic                  q_valid,
  output map_pkg::entry_ctl_t   q_ctl,
  output logic [COUNT_BITS-1:0] q_count,
  input  logic                  q_pop
);
  import map_pkg::*;

  logic [COUNT_BITS-1:0] cnt;
  entry_ctl_t            ctl_in;
  logic                  push;

  entry_ctl_t            ctl_mem [QDEPTH];
  logic [COUNT_BITS-1:0] cnt_mem [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r;
  logic [QPTR_W-1:0]     rd_ptr_r;
  logic [QPTR_W:0]       fill_r;

  // Only the low COUNT_BITS bits of the count take part.
  assign cnt = in_count[COUNT_BITS-1:0];

  // Classify the entry: skip, multiply, zero result or invalid order.
  always_comb begin
    ctl_in.order = in_order;
    ctl_in.last  = in_last_species;
    if (in_order == '0) begin
      ctl_in.kind = KIND_SKIP;
    end else if (in_order > MAX_ORDER) begin
      ctl_in.kind = KIND_BAD;
    end else if (COUNT_BITS'(in_order) > cnt) begin
      ctl_in.kind = KIND_ZERO;
    end else begin
      ctl_in.kind = KIND_MUL;
    end
  end

  assign in_stall = (fill_r == (QPTR_W+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != '0);
  assign q_ctl    = ctl_mem[rd_ptr_r];
  assign q_count  = cnt_mem[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr_r] <= ctl_in;
      cnt_mem[wr_ptr_r] <= cnt;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (!push && q_pop) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

[rtl/map_mul.sv]
// Saturating 64 by 48 bit multiplier built from one 32x32 unit over several cycles.
module map_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         a,
  input  logic [47:0]         b,
  output map_pkg::mul_stat_t  stat,
  output logic [63:0]         res
);
  import map_pkg::*;

  localparam logic [1:0] SH0  = 2'd0;
  localparam logic [1:0] SH32 = 2'd1;
  localparam logic [1:0] SH64 = 2'd2;

  logic [63:0] a_r;
  logic [47:0] b_r;
  logic        issuing_r;
  logic [1:0]  step_r;
  logic [63:0] pp_r;
  logic        pp_v_r;
  logic [1:0]  pp_sh_r;
  logic        pp_last_r;
  logic [95:0] acc_r;
  logic        ovf_r;
  logic        done_r;

  logic [1:0]  last_step;
  logic [31:0] a_sel;
  logic [31:0] b_sel;
  logic [1:0]  sh_sel;
  logic [63:0] pp_w;
  logic [96:0] sum;
  logic        sat_w;

  // A multiplier below 2^32 needs only the two lower partial products.
  assign last_step = (b_r[47:32] == '0) ? 2'd1 : 2'd3;

  // Partial product selection for the current step.
  always_comb begin
    case (step_r)
      2'd0: begin
        a_sel  = a_r[31:0];
        b_sel  = b_r[31:0];
        sh_sel = SH0;
      end
      2'd1: begin
        a_sel  = a_r[63:32];
        b_sel  = b_r[31:0];
        sh_sel = SH32;
      end
      2'd2: begin
        a_sel  = a_r[31:0];
        b_sel  = {16'd0, b_r[47:32]};
        sh_sel = SH32;
      end
      default: begin
        a_sel  = a_r[63:32];
        b_sel  = {16'd0, b_r[47:32]};
        sh_sel = SH64;
      end
    endcase
  end

  assign pp_w = a_sel * b_sel;

  // Add the registered partial product at its weight.
  assign sum = {1'b0, acc_r} +
               ((pp_sh_r == SH32) ? {1'b0, pp_r, 32'd0} : {33'd0, pp_r});

  // Control of the step sequence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      pp_v_r    <= 1'b0;
      done_r    <= 1'b0;
      step_r    <= '0;
    end else begin
      done_r <= pp_v_r && pp_last_r;
      pp_v_r <= issuing_r;
      if (start) begin
        issuing_r <= 1'b1;
        step_r    <= '0;
      end else if (issuing_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == last_step) begin
          issuing_r <= 1'b0;
        end
      end
    end
  end

  // Operands, partial product and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
      ovf_r <= 1'b0;
    end else if (pp_v_r) begin
      if (pp_sh_r == SH64) begin
        ovf_r <= ovf_r || (pp_r != '0);
      end else begin
        acc_r <= sum[95:0];
        ovf_r <= ovf_r || sum[96];
      end
    end
    if (issuing_r) begin
      pp_r      <= pp_w;
      pp_sh_r   <= sh_sel;
      pp_last_r <= (step_r == last_step);
    end
  end

  // Saturate on an overflow or when any bit at position 64 or above is set.
  assign sat_w     = ovf_r || (acc_r[95:64] != '0);
  assign res       = sat_w ? '1 : acc_r[63:0];
  assign stat.done = done_r;
  assign stat.sat  = sat_w;

endmodule

[rtl/map_back.sv]
// Back end: runs the falling factorials and the rate product, and holds the result.
module map_back #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  map_pkg::entry_ctl_t   q_ctl,
  input  logic [COUNT_BITS-1:0] q_count,
  output logic                  q_pop,
  input  logic [47:0]           rate_const,
  input  logic                  active,
  output logic                  mul_start,
  output logic [63:0]           mul_a,
  output logic [47:0]           mul_b,
  input  map_pkg::mul_stat_t    mul_stat,
  input  logic [63:0]           mul_res,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           out_combinatorial_factor,
  output logic [63:0]           out_propensity,
  output logic                  out_saturated,
  output logic                  out_bad_order
);
  import map_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_FINAL = 3'd2;
  localparam logic [2:0] ST_PROP  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [63:0]           prod_r, prod_nxt;
  logic                  zero_r, zero_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  bad_r, bad_nxt;
  logic [ORDER_W-1:0]    order_r, order_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  last_r, last_nxt;
  logic [ORDER_W-1:0]    k_r, k_nxt;
  logic [63:0]           fact_r, fact_nxt;
  logic [63:0]           prop_r, prop_nxt;
  logic                  psat_r, psat_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [63:0]           out_fact_r, out_fact_nxt;
  logic [63:0]           out_prop_r, out_prop_nxt;
  logic                  out_sat_r, out_sat_nxt;
  logic                  out_bad_r, out_bad_nxt;
  logic [ORDER_W-1:0]    k_inc;

  assign k_inc = k_r + 1'b1;

  // Sequencer over queued entries.
  always_comb begin
    state_nxt     = state_r;
    prod_nxt      = prod_r;
    zero_nxt      = zero_r;
    ovf_nxt       = ovf_r;
    bad_nxt       = bad_r;
    order_nxt     = order_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    k_nxt         = k_r;
    fact_nxt      = fact_r;
    prop_nxt      = prop_r;
    psat_nxt      = psat_r;
    out_valid_nxt = out_valid_r;
    out_fact_nxt  = out_fact_r;
    out_prop_nxt  = out_prop_r;
    out_sat_nxt   = out_sat_r;
    out_bad_nxt   = out_bad_r;
    q_pop         = 1'b0;
    mul_start     = 1'b0;
    mul_a         = prod_r;
    mul_b         = 48'(cnt_r - COUNT_BITS'(k_r));

    // The held result leaves when the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          order_nxt = q_ctl.order;
          cnt_nxt   = q_count;
          last_nxt  = q_ctl.last;
          k_nxt     = '0;
          case (q_ctl.kind)
            KIND_MUL: begin
              mul_start = 1'b1;
              mul_b     = 48'(q_count);
              state_nxt = ST_MUL;
            end
            KIND_BAD: begin
              bad_nxt   = 1'b1;
              zero_nxt  = 1'b1;
              state_nxt = q_ctl.last ? ST_FINAL : ST_IDLE;
            end
            KIND_ZERO: begin
              zero_nxt  = 1'b1;
              state_nxt = q_ctl.last ? ST_FINAL : ST_IDLE;
            end
            default: begin
              state_nxt = q_ctl.last ? ST_FINAL : ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          prod_nxt = mul_res;
          ovf_nxt  = ovf_r || mul_stat.sat;
          k_nxt    = k_inc;
          if (k_inc == order_r) begin
            state_nxt = last_r ? ST_FINAL : ST_IDLE;
          end else begin
            mul_start = 1'b1;
            mul_a     = mul_res;
            mul_b     = 48'(cnt_r - COUNT_BITS'(k_inc));
          end
        end
      end
      ST_FINAL: begin
        if (active && !zero_r) begin
          mul_start = 1'b1;
          mul_a     = prod_r;
          mul_b     = rate_const;
          fact_nxt  = prod_r;
          state_nxt = ST_PROP;
        end else begin
          fact_nxt  = '0;
          prop_nxt  = '0;
          psat_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end
      end
      ST_PROP: begin
        if (mul_stat.done) begin
          prop_nxt  = mul_res;
          psat_nxt  = ovf_r || mul_stat.sat;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_fact_nxt  = fact_r;
          out_prop_nxt  = prop_r;
          out_sat_nxt   = psat_r;
          out_bad_nxt   = bad_r;
          prod_nxt      = 64'd1;
          zero_nxt      = 1'b0;
          ovf_nxt       = 1'b0;
          bad_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and reaction accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prod_r      <= 64'd1;
      zero_r      <= 1'b0;
      ovf_r       <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prod_r      <= prod_nxt;
      zero_r      <= zero_nxt;
      ovf_r       <= ovf_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Entry fields and result payload.
  always_ff @(posedge clk) begin
    order_r    <= order_nxt;
    cnt_r      <= cnt_nxt;
    last_r     <= last_nxt;
    k_r        <= k_nxt;
    fact_r     <= fact_nxt;
    prop_r     <= prop_nxt;
    psat_r     <= psat_nxt;
    out_fact_r <= out_fact_nxt;
    out_prop_r <= out_prop_nxt;
    out_sat_r  <= out_sat_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid                = out_valid_r;
  assign out_combinatorial_factor = out_fact_r;
  assign out_propensity           = out_prop_r;
  assign out_saturated            = out_sat_r;
  assign out_bad_order            = out_bad_r;

endmodule

[rtl/mass_action_propensity.sv]
// Top level of the mass-action propensity block.
//
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid / in_stall  order, count, last_species
//  out_     output     out_valid/out_stall  combinatorial_factor, propensity, saturated, bad_order
//  cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An entry of order 0 or an entry that forces a zero result passes through the
// back end without a multiply; an entry of order n runs n products on the single shared
// 32x32 multiplier, each a saturating 64x32 product built from its partial products.
// The last entry of a reaction adds the rate product, when active and nonzero, and the hand-off;
// a rate constant of 2^32 or more needs all four partial products, and a stalled result delays it.
// A two-entry queue lets the front accept items while the back end multiplies.
// Reset is synchronous and needs no clearing pass; cfg_ready is always high.
// A stalled result is held in the output register while the back end keeps working.
module mass_action_propensity #(
  parameter int COUNT_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         in_order,
  input  logic [31:0]                        in_count,
  input  logic                               in_last_species,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [63:0]                        out_combinatorial_factor,
  output logic [63:0]                        out_propensity,
  output logic                               out_saturated,
  output logic                               out_bad_order,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [map_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [map_pkg::RATE_W-1:0]         cfg_data
);
  import map_pkg::*;

  logic [RATE_W-1:0]     rate_const_r;
  logic                  active_r;
  logic                  q_valid;
  entry_ctl_t            q_ctl;
  logic [COUNT_BITS-1:0] q_count;
  logic                  q_pop;
  logic                  mul_start;
  logic [63:0]           mul_a;
  logic [47:0]           mul_b;
  mul_stat_t             mul_stat;
  logic [63:0]           mul_res;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_const_r <= '0;
      active_r     <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RATE_CONST: rate_const_r <= cfg_data;
        REG_ACTIVE:     active_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  map_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_order        (in_order),
    .in_count        (in_count),
    .in_last_species (in_last_species),
    .q_valid         (q_valid),
    .q_ctl           (q_ctl),
    .q_count         (q_count),
    .q_pop           (q_pop)
  );

  map_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .res   (mul_res)
  );

  map_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .q_valid                  (q_valid),
    .q_ctl                    (q_ctl),
    .q_count                  (q_count),
    .q_pop                    (q_pop),
    .rate_const               (rate_const_r),
    .active                   (active_r),
    .mul_start                (mul_start),
    .mul_a                    (mul_a),
    .mul_b                    (mul_b),
    .mul_stat                 (mul_stat),
    .mul_res                  (mul_res),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_combinatorial_factor (out_combinatorial_factor),
    .out_propensity           (out_propensity),
    .out_saturated            (out_saturated),
    .out_bad_order            (out_bad_order)
  );

endmodule

[rtl/map_checker.sv]
// Port-level checks of the mass-action propensity block and their binding.
module map_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_combinatorial_factor,
  input logic [63:0] out_propensity,
  input logic        out_saturated
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled propensity does not change.
  a_prop_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_propensity))
    else $error("propensity changed while stalled");

  // A zero factor means a zero result throughout.
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_combinatorial_factor == 64'd0) |-> (out_propensity == 64'd0) &&
      !out_saturated)
    else $error("zero factor with nonzero propensity or saturation");

  // A nonzero propensity needs a nonzero factor.
  a_prop_needs_factor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_propensity != 64'd0) |-> (out_combinatorial_factor != 64'd0))
    else $error("nonzero propensity with zero factor");

endmodule

bind mass_action_propensity map_checker u_map_checker (.*);
